// File: hdl/spmv_pkg.sv
// Package for the CSR sparse matrix-vector multiply block.
// Sizes, item codes and the structs passed between front, queue and back.
// No dependencies.
package spmv_pkg;

	// Store and counter sizes
	localparam int MAX_COLUMNS = 8192;
	localparam int MAX_ROWS    = 16384;
	localparam int ADDR_W      = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);

	// Fixed field widths
	localparam int FUNC_W = 2;
	localparam int COL_W  = 13;
	localparam int VAL_W  = 32;
	localparam int IDX_W  = 14;
	localparam int ACC_W  = 64;
	localparam int PROD_W = 2 * VAL_W;

	// Work queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Item function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_NONZERO = 2'd1,
		FUNC_EMPTY   = 2'd2
	} func_t;

	// One queued word of work for the back end
	typedef struct packed {
		logic                    is_empty;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] x;
		logic                    row_end;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t data;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		work_t data;
	} q_head_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_status_t;

	// Vector store access from the front end
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// File: hdl/spmv_if.sv
// Valid/ready channel interfaces for the sparse matrix-vector multiply block.
// Depends on spmv_pkg for field widths.
interface spmv_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [spmv_pkg::FUNC_W-1:0]          func;
	logic [spmv_pkg::COL_W-1:0]           column;
	logic signed [spmv_pkg::VAL_W-1:0]    value;
	logic                                 row_end;

	modport source (output valid, func, column, value, row_end, input ready);
	modport sink   (input valid, func, column, value, row_end, output ready);
endinterface

interface spmv_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [spmv_pkg::IDX_W-1:0]           row_index;
	logic signed [spmv_pkg::VAL_W-1:0]    row_result;
	logic                                 overflow;

	modport source (output valid, row_index, row_result, overflow, input ready);
	modport sink   (input valid, row_index, row_result, overflow, output ready);
endinterface

// File: hdl/spmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/spmv_front.sv
// Front end: accepts input words, writes vector loads to the store, reads x for
// nonzeros and pushes nonzero and empty-row work into the queue.
// Depends on spmv_pkg, spmv_if.
module spmv_front (
	input  logic                        clk,
	input  logic                        arst_n,
	spmv_in_if.sink                     in_ch,
	input  spmv_pkg::q_status_t         q_stat,
	output spmv_pkg::q_push_t           push,
	output spmv_pkg::ram_req_t          ram_req,
	input  logic [spmv_pkg::VAL_W-1:0]  ram_rdata
);

	logic                              accept;
	logic                              in_range;
	logic                              v_s1;
	logic                              empty_s1;
	logic                              in_range_s1;
	logic signed [spmv_pkg::VAL_W-1:0] value_s1;
	logic                              last_s1;
	logic                              is_load;
	logic                              is_work;
	logic                              work_empty;

	// Credit check: queued words plus the one in flight must leave room
	assign in_ch.ready = (({1'b0, q_stat.count}) + (spmv_pkg::QCNT_W+1)'(v_s1))
		< (spmv_pkg::QCNT_W+1)'(spmv_pkg::QDEPTH);
	assign accept   = in_ch.valid && in_ch.ready;
	assign in_range = 32'(in_ch.column) < 32'(spmv_pkg::MAX_COLUMNS);

	// Classify the incoming word
	always_comb begin
		is_load    = 1'b0;
		is_work    = 1'b0;
		work_empty = 1'b0;
		case (in_ch.func)
			spmv_pkg::FUNC_LOAD: begin
				is_load = 1'b1;
			end
			spmv_pkg::FUNC_NONZERO: begin
				is_work = 1'b1;
			end
			spmv_pkg::FUNC_EMPTY: begin
				is_work    = 1'b1;
				work_empty = 1'b1;
			end
			default: begin
				is_load = 1'b0;
			end
		endcase
	end

	// Vector store access
	assign ram_req.we    = accept && is_load && in_range;
	assign ram_req.waddr = spmv_pkg::ADDR_W'(in_ch.column);
	assign ram_req.wdata = in_ch.value;
	assign ram_req.re    = accept && is_work && !work_empty;
	assign ram_req.raddr = spmv_pkg::ADDR_W'(in_ch.column);

	// Stage 1: wait for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && is_work;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_work) begin
			empty_s1    <= work_empty;
			in_range_s1 <= in_range;
			value_s1    <= in_ch.value;
			last_s1     <= in_ch.row_end;
		end
	end

	// Queue push, x forced to zero for empty rows and columns past the store
	assign push.valid         = v_s1;
	assign push.data.is_empty = empty_s1;
	assign push.data.value    = value_s1;
	assign push.data.x        = (empty_s1 || !in_range_s1) ? '0 : ram_rdata;
	assign push.data.row_end  = last_s1;

endmodule

// File: hdl/spmv_queue.sv
// Short work queue that decouples the front end from the back end.
// Depends on spmv_pkg.
module spmv_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spmv_pkg::q_push_t    push,
	input  logic                 pop,
	output spmv_pkg::q_head_t    head,
	output spmv_pkg::q_status_t  q_stat
);

	spmv_pkg::work_t             entry_q [spmv_pkg::QDEPTH];
	logic [spmv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [spmv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [spmv_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign do_pop  = pop && (count_q != '0);
	assign do_push = push.valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == spmv_pkg::QPTR_W'(spmv_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == spmv_pkg::QPTR_W'(spmv_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	assign head.valid   = count_q != '0;
	assign head.data    = entry_q[rd_ptr_q];
	assign q_stat.count = count_q;

endmodule

// File: hdl/spmv_back.sv
// Back end: multiplies value by x, rounds to Q16.16, accumulates with 64-bit
// saturation, closes rows and holds the result in the output register.
// Depends on spmv_pkg, spmv_if.
module spmv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  spmv_pkg::q_head_t  head,
	output logic               pop,
	spmv_out_if.source         out_ch
);

	localparam int SUM_W = spmv_pkg::ACC_W + 2;

	logic                               adv;
	logic signed [spmv_pkg::PROD_W-1:0] mul;
	logic                               v_s1;
	logic signed [spmv_pkg::PROD_W-1:0] prod_s1;
	logic                               empty_s1;
	logic                               last_s1;
	logic signed [spmv_pkg::ACC_W-1:0]  acc_q;
	logic [spmv_pkg::ROW_W-1:0]         row_cnt_q;
	logic [SUM_W-1:0]                   sum_wide;
	logic signed [spmv_pkg::ACC_W-1:0]  sum_sat;
	logic signed [spmv_pkg::ACC_W-1:0]  acc_next;
	logic                               emit;
	logic                               emit_v_s2;
	logic signed [spmv_pkg::ACC_W-1:0]  emit_acc_s2;
	logic [spmv_pkg::ROW_W-1:0]         emit_row_s2;
	logic                               out_valid_q;
	logic [spmv_pkg::IDX_W-1:0]         out_row_q;
	logic signed [spmv_pkg::VAL_W-1:0]  out_res_q;
	logic                               out_ovf_q;
	logic                               res_ovf;
	logic signed [spmv_pkg::VAL_W-1:0]  res_sat;

	// Whole back pipeline moves when the output register can take a word
	assign adv = !out_valid_q || out_ch.ready;
	assign pop = head.valid && adv;

	// Stage 1: signed 32x32 product
	assign mul = head.data.value * head.data.x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= mul;
			empty_s1 <= head.data.is_empty;
			last_s1  <= head.data.row_end;
		end
	end

	// Round to nearest (carry in from bit 15) and add to the accumulator
	assign sum_wide = {{2{acc_q[spmv_pkg::ACC_W-1]}}, acc_q}
		+ {{(SUM_W - spmv_pkg::PROD_W + 16){prod_s1[spmv_pkg::PROD_W-1]}},
		   prod_s1[spmv_pkg::PROD_W-1:16]}
		+ SUM_W'(prod_s1[15]);

	always_comb begin
		if (sum_wide[SUM_W-1:spmv_pkg::ACC_W-1] == '0 ||
		    sum_wide[SUM_W-1:spmv_pkg::ACC_W-1] == '1) begin
			sum_sat = sum_wide[spmv_pkg::ACC_W-1:0];
		end else if (sum_wide[SUM_W-1]) begin
			sum_sat = {1'b1, {(spmv_pkg::ACC_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(spmv_pkg::ACC_W-1){1'b1}}};
		end
	end

	assign acc_next = empty_s1 ? acc_q : sum_sat;
	assign emit     = v_s1 && (empty_s1 || last_s1);

	// Stage 2: accumulator, row counter and closed-row value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			row_cnt_q <= '0;
			emit_v_s2 <= 1'b0;
		end else if (adv) begin
			emit_v_s2 <= emit;
			if (v_s1) begin
				acc_q <= emit ? '0 : acc_next;
			end
			if (emit) begin
				row_cnt_q <= (row_cnt_q == spmv_pkg::ROW_W'(spmv_pkg::MAX_ROWS - 1)) ?
					'0 : row_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			emit_acc_s2 <= acc_next;
			emit_row_s2 <= row_cnt_q;
		end
	end

	// Saturate to 32 bits for the result
	always_comb begin
		res_ovf = !(emit_acc_s2[spmv_pkg::ACC_W-1:spmv_pkg::VAL_W-1] == '0 ||
		            emit_acc_s2[spmv_pkg::ACC_W-1:spmv_pkg::VAL_W-1] == '1);
		if (!res_ovf) begin
			res_sat = emit_acc_s2[spmv_pkg::VAL_W-1:0];
		end else if (emit_acc_s2[spmv_pkg::ACC_W-1]) begin
			res_sat = {1'b1, {(spmv_pkg::VAL_W-1){1'b0}}};
		end else begin
			res_sat = {1'b0, {(spmv_pkg::VAL_W-1){1'b1}}};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_v_s2) begin
			out_row_q <= spmv_pkg::IDX_W'(emit_row_s2);
			out_res_q <= res_sat;
			out_ovf_q <= res_ovf;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.row_index  = out_row_q;
	assign out_ch.row_result = out_res_q;
	assign out_ch.overflow   = out_ovf_q;

endmodule

// File: hdl/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix-vector multiply (y = A*x, Q16.16).
// Depends on spmv_pkg, spmv_if, spmv_ram, spmv_front, spmv_queue, spmv_back.
//
// Load x first (func 0, one element per word, column as index), then stream the
// nonzeros row by row (func 1) with row_end on the last one of each row, or a
// func 2 word for an empty row; each closed row returns one result word with
// its row index, the 32-bit saturated dot product and an overflow flag. The
// block takes one word per clock when the output side keeps up: the front end
// reads the vector store into its stage 1 register, and the back end has a single
// multiplier and one 64-bit accumulate, both at one word per cycle. A closed
// row reaches the output through the store read on the accepting edge, then the
// queue write, the multiply, the accumulate and the output register. The
// four-entry work queue absorbs output stalls; input ready drops once the
// queued words plus the one in the store read stage reach four.
// The vector store starts undefined: every x entry must be loaded before a
// nonzero uses it, and no clearing pass runs after reset.
module csr_sparse_matrix_vector_multiply (
	input  logic        clk,
	input  logic        arst_n,
	spmv_in_if.sink     in_ch,
	spmv_out_if.source  out_ch
);

	spmv_pkg::q_status_t            q_stat;
	spmv_pkg::q_push_t              push;
	spmv_pkg::q_head_t              head;
	spmv_pkg::ram_req_t             ram_req;
	logic [spmv_pkg::VAL_W-1:0]     ram_rdata;
	logic                           pop;

	spmv_ram #(
		.WIDTH (spmv_pkg::VAL_W),
		.DEPTH (spmv_pkg::MAX_COLUMNS)
	) u_vec_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	spmv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_stat    (q_stat),
		.push      (push),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	spmv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	spmv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// Fill count never passes the queue depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= spmv_pkg::QCNT_W'(spmv_pkg::QDEPTH))
		else $error("work queue count beyond depth");

	// The input credit check keeps the front end from pushing into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count == spmv_pkg::QCNT_W'(spmv_pkg::QDEPTH)) |-> !push.valid)
		else $error("push into full work queue");

	// A word accepted for the back end reaches the queue the next cycle
	a_push_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready &&
		 (in_ch.func == spmv_pkg::FUNC_NONZERO || in_ch.func == spmv_pkg::FUNC_EMPTY))
		|=> push.valid)
		else $error("accepted work word not pushed");

	// The back end pops only a queue that holds work
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty work queue");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the CSR sparse matrix-vector multiply block.
// Depends on spmv_pkg, the spmv_in_if/spmv_out_if channels and the block's RTL.
// Predicts each row word from a local copy of x, the row sum and the row count.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Code outside the func_t enum, which the block must ignore
	localparam logic [spmv_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int RANDOM_WORDS = 1100;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;

	localparam logic signed [spmv_pkg::VAL_W-1:0] Q_TOP = 32'sh7FFF_FFFF;
	localparam logic signed [spmv_pkg::VAL_W-1:0] Q_BOT = 32'sh8000_0000;
	localparam longint Q_TOP_L = 64'sd2147483647;
	localparam longint Q_BOT_L = -64'sd2147483648;

	typedef struct packed {
		logic [spmv_pkg::FUNC_W-1:0]       func;
		logic [spmv_pkg::COL_W-1:0]        column;
		logic signed [spmv_pkg::VAL_W-1:0] value;
		logic                              row_end;
	} spmv_word_t;

	typedef struct packed {
		logic [spmv_pkg::IDX_W-1:0]        row_index;
		logic signed [spmv_pkg::VAL_W-1:0] row_result;
		logic                              overflow;
	} row_word_t;

	logic clk = 1'b0;
	logic arst_n;

	spmv_in_if  in_ch ();
	spmv_out_if out_ch ();

	csr_sparse_matrix_vector_multiply dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Words waiting to go in, and row words the block still owes
	spmv_word_t spmv_words[$];
	row_word_t  row_results_due[$];

	// Predicted block state
	logic signed [spmv_pkg::VAL_W-1:0] x_store [spmv_pkg::MAX_COLUMNS];
	longint                            row_sum;
	logic [spmv_pkg::IDX_W-1:0]        row_count;

	// Generator bookkeeping: only loaded columns may be used by a nonzero
	bit col_loaded [spmv_pkg::MAX_COLUMNS];
	int unsigned loaded_cols[$];
	int unsigned counted_words;

	int unsigned words_taken;
	int unsigned mismatches;

	// Emit the saturated row sum and start the next row
	task automatic close_row();
		row_word_t r;
		r.row_index = row_count;
		r.overflow  = 1'b0;
		if (row_sum > Q_TOP_L) begin
			r.row_result = Q_TOP;
			r.overflow   = 1'b1;
		end else if (row_sum < Q_BOT_L) begin
			r.row_result = Q_BOT;
			r.overflow   = 1'b1;
		end else begin
			r.row_result = spmv_pkg::VAL_W'(row_sum);
		end
		row_results_due.push_back(r);
		row_sum   = 0;
		row_count = spmv_pkg::IDX_W'((int'(row_count) + 1) % spmv_pkg::MAX_ROWS);
	endtask

	// Apply one accepted word to the predicted state
	task automatic accumulate_word(spmv_word_t w);
		longint                          prod;
		longint                          x;
		logic signed [spmv_pkg::ACC_W:0] sum;
		case (w.func)
			spmv_pkg::FUNC_LOAD: begin
				if (w.column < spmv_pkg::MAX_COLUMNS)
					x_store[w.column] = w.value;
			end
			spmv_pkg::FUNC_NONZERO: begin
				x = 0;
				if (w.column < spmv_pkg::MAX_COLUMNS)
					x = longint'(x_store[w.column]);
				// Q32.32 product, rounded half up back to Q16.16
				prod = longint'(w.value) * x;
				prod = (prod + 64'sd32768) >>> 16;
				sum = row_sum;
				sum = sum + prod;
				if (sum[spmv_pkg::ACC_W] != sum[spmv_pkg::ACC_W-1])
					row_sum = sum[spmv_pkg::ACC_W] ? 64'h8000_0000_0000_0000 :
						64'h7FFF_FFFF_FFFF_FFFF;
				else
					row_sum = sum[spmv_pkg::ACC_W-1:0];
				if (w.row_end)
					close_row();
			end
			spmv_pkg::FUNC_EMPTY: begin
				close_row();
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_word(logic [spmv_pkg::FUNC_W-1:0] f, logic [spmv_pkg::COL_W-1:0] col,
			logic signed [spmv_pkg::VAL_W-1:0] val, logic re);
		spmv_word_t w;
		w.func    = f;
		w.column  = col;
		w.value   = val;
		w.row_end = re;
		spmv_words.push_back(w);
		if (f != FUNC_UNUSED)
			counted_words++;
	endtask

	task automatic load_column(logic [spmv_pkg::COL_W-1:0] col,
			logic signed [spmv_pkg::VAL_W-1:0] val, logic re);
		queue_word(spmv_pkg::FUNC_LOAD, col, val, re);
		if (!col_loaded[col]) begin
			col_loaded[col] = 1'b1;
			loaded_cols.push_back(int'(col));
		end
	endtask

	// Mostly small Q16.16 values, with extremes and full-range noise
	function automatic logic signed [spmv_pkg::VAL_W-1:0] pick_value();
		logic signed [spmv_pkg::VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = Q_TOP;
			1: v = Q_BOT;
			2: v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
			3, 4: v = $urandom;
			default: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
		return v;
	endfunction

	function automatic logic [spmv_pkg::COL_W-1:0] pick_loaded_col();
		return spmv_pkg::COL_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
	endfunction

	// Stimulus, reset and end of run
	initial begin
		int unsigned pick;
		int unsigned len;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.func      = '0;
		in_ch.column    = '0;
		in_ch.value     = '0;
		in_ch.row_end   = 1'b0;
		out_ch.ready    = 1'b0;
		row_sum         = 0;
		row_count       = '0;
		counted_words   = 0;
		words_taken     = 0;
		mismatches      = 0;

		// Directed: extremes, rounding ties, saturation, ignored fields and codes
		load_column(spmv_pkg::COL_W'(0), Q_TOP, 1'b0);
		// row_end on a load is ignored
		load_column(spmv_pkg::COL_W'(spmv_pkg::MAX_COLUMNS - 1), Q_BOT, 1'b1);
		load_column(13'h1555, 32'sh0001_0000, 1'b0);
		load_column(13'h0AAA, -32'sd1, 1'b1);
		load_column(spmv_pkg::COL_W'(1), 32'sh0000_8000, 1'b0);
		queue_word(FUNC_UNUSED, 13'h1FFF, 32'sh5A5A_A5A5, 1'b1);
		queue_word(spmv_pkg::FUNC_EMPTY, spmv_pkg::COL_W'(0), Q_TOP, 1'b1); // empty row: zero
		queue_word(spmv_pkg::FUNC_NONZERO, 13'h1555, 32'sh0003_0000, 1'b0);
		queue_word(spmv_pkg::FUNC_NONZERO, 13'h0AAA, 32'sh0000_8000, 1'b0); // tie up to 0
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(1), 32'sd1, 1'b1); // tie up to 1
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(0), Q_TOP, 1'b0);
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(0), Q_TOP, 1'b0);
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(0), Q_TOP, 1'b1); // positive sat
		// largest product
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(spmv_pkg::MAX_COLUMNS - 1),
			Q_BOT, 1'b1);
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(0), Q_BOT, 1'b1); // negative sat
		queue_word(spmv_pkg::FUNC_NONZERO, 13'h1555, -32'sh0002_0000, 1'b0);
		queue_word(spmv_pkg::FUNC_EMPTY, spmv_pkg::COL_W'(0), '0, 1'b0); // closes the open row
		queue_word(spmv_pkg::FUNC_NONZERO, spmv_pkg::COL_W'(1), '0, 1'b1);
		load_column(13'h0AAA, 32'sh7FFF_0000, 1'b0);              // overwrite
		queue_word(spmv_pkg::FUNC_NONZERO, 13'h0AAA, Q_TOP, 1'b1);
		queue_word(FUNC_UNUSED, '0, '0, 1'b0);

		// Random: a vector preload, then mostly well-formed rows
		repeat (48)
			load_column(spmv_pkg::COL_W'($urandom_range(0, spmv_pkg::MAX_COLUMNS - 1)),
				pick_value(), 1'($urandom_range(0, 1)));
		while (counted_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 6))
					load_column(spmv_pkg::COL_W'($urandom_range(0, spmv_pkg::MAX_COLUMNS - 1)),
						pick_value(), 1'($urandom_range(0, 1)));
			end else if (pick < 13) begin
				queue_word(spmv_pkg::FUNC_EMPTY, spmv_pkg::COL_W'($urandom), $urandom,
					1'($urandom_range(0, 1)));
			end else if (pick < 15) begin
				queue_word(FUNC_UNUSED, spmv_pkg::COL_W'($urandom), $urandom,
					1'($urandom_range(0, 1)));
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				for (int unsigned k = 0; k < len; k++)
					queue_word(spmv_pkg::FUNC_NONZERO, pick_loaded_col(), pick_value(),
						k == len - 1);
				// now and then an empty-row word closes a row left open
				if ($urandom_range(0, 19) == 0) begin
					queue_word(spmv_pkg::FUNC_NONZERO, pick_loaded_col(), pick_value(), 1'b0);
					queue_word(spmv_pkg::FUNC_EMPTY, '0, '0, 1'b0);
				end
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (spmv_words.size() != 0 || row_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("csr_sparse_matrix_vector_multiply: match");
		else
			$display("csr_sparse_matrix_vector_multiply: mismatch");
		$finish;
	end

	// Driver: bursts of words with random gaps, valid held until taken
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.func    <= '0;
			in_ch.column  <= '0;
			in_ch.value   <= '0;
			in_ch.row_end <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				accumulate_word(spmv_words.pop_front());
				words_taken++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (spmv_words.size() == 0) begin
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid   <= 1'b1;
					in_ch.func    <= spmv_words[0].func;
					in_ch.column  <= spmv_words[0].column;
					in_ch.value   <= spmv_words[0].value;
					in_ch.row_end <= spmv_words[0].row_end;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 32);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Long output hold-off once traffic is underway, so the input stalls
	logic        hold_off;
	int unsigned hold_count;
	bit          hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off   <= 1'b0;
			hold_count = 0;
			hold_done  = 1'b0;
		end else if (hold_off) begin
			hold_count++;
			if (hold_count == HOLD_CYCLES) begin
				hold_off  <= 1'b0;
				hold_done = 1'b1;
			end
		end else if (!hold_done && words_taken >= HOLD_AFTER) begin
			hold_off <= 1'b1;
		end
	end

	// Receiver: ready follows one of four stall patterns, picked at random
	int unsigned stall_phase;
	int unsigned stall_mode;
	bit          sink_take;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase = 0;
			stall_mode  = 0;
		end else begin
			stall_phase++;
			if (stall_phase % 96 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: sink_take = 1'b1;
				1: sink_take = 1'($urandom_range(0, 1));
				2: sink_take = (stall_phase % 4) != 0;
				default: sink_take = (stall_phase % 16) < 5;
			endcase
			out_ch.ready <= sink_take && !hold_off;
		end
	end

	// Monitor: each taken row word against the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (row_results_due.size() == 0) begin
				$error("row word with none due: row_index %0d row_result %0h",
					out_ch.row_index, out_ch.row_result);
				mismatches++;
			end else begin
				row_word_t due;
				due = row_results_due.pop_front();
				if (out_ch.row_index !== due.row_index) begin
					$error("row_index: expected %0d, actual %0d", due.row_index, out_ch.row_index);
					mismatches++;
				end
				if (out_ch.row_result !== due.row_result) begin
					$error("row_result: expected %0h, actual %0h", due.row_result,
						out_ch.row_result);
					mismatches++;
				end
				if (out_ch.overflow !== due.overflow) begin
					$error("overflow: expected %0b, actual %0b", due.overflow, out_ch.overflow);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles where neither channel moves a word
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("csr_sparse_matrix_vector_multiply: mismatch");
				$finish;
			end
		end
	end

endmodule
